FILE: design/perlin_noise_3d_top_defines.svh
// Assertion macros used by the checker of the noise block.
`ifndef PERLIN_NOISE_3D_TOP_DEFINES_SVH
`define PERLIN_NOISE_3D_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PN3D_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PN3D_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pn3d_pkg.sv
package pn3d_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);

  localparam int GRAD_W     = 16;
  localparam int OUT_W      = 20;
  localparam int S_TDATA_W  = 160;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 24;

  // Request kinds carried in tuser.
  localparam logic [S_TUSER_W-1:0] FUNC_EVAL = 2'd0;
  localparam logic [S_TUSER_W-1:0] FUNC_GRAD = 2'd1;
  localparam logic [S_TUSER_W-1:0] FUNC_PERM = 2'd2;
  localparam logic [S_TUSER_W-1:0] FUNC_RSVD = 2'd3;

  localparam logic signed [23:0] OUT_MAX = 24'sd524287;
  localparam logic signed [23:0] OUT_MIN = -24'sd524288;

endpackage

FILE: design/pn3d_ram.sv
module pn3d_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [DATA_W-1:0]        rdata0_o,
  output logic [DATA_W-1:0]        rdata1_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

FILE: design/perlin_noise_3d_top.sv
// Channel   Direction  tdata                                   tuser
// s_axis    in         coord_x/y/z, table_index, grad_x/y/z,   func
//                      perm_value
// m_axis    out        noise_value (signed Q3.16)              -
//
// One request enters per cycle while the output is not stalled. The pipe registers
// the request, the three chained permutation reads, the gradient read, the dot products
// (products, sums), three interpolation levels (difference, product, sum) and the result.
// Table writes travel down the pipe and land in each table copy at the stage
// that reads it, so every request sees exactly the writes accepted before it.
// One enable advances the whole pipe; it drops only while a result waits.
// Reset clears the valid bits only; table contents are undefined until written.
module perlin_noise_3d_top import pn3d_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // coord_x[31:0], coord_y[63:32], coord_z[95:64], table_index[103:96],
  // grad_x[119:104], grad_y[135:120], grad_z[151:136], perm_value[159:152]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // func[1:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // noise_value[19:0], zero fill [23:20]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int NST = 16;

  // Global advance: hold everything while the output register is full and stalled.
  logic en;
  logic [NST:1] vld_q, vld_d;
  logic         out_vld_q;
  logic [OUT_W-1:0] out_q, out_d;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, out_q};

  // Request fields carried down to where they are used.
  logic [S_TUSER_W-1:0]       func_q  [1:4];
  logic [2:0][IDX_W-1:0]      cell_q  [1:3];
  logic [2:0][FRAC_BITS-1:0]  frac_q  [1:5];
  logic [IDX_W-1:0]           widx_q  [1:4];
  logic [3*GRAD_W-1:0]        wgrad_q [1:4];
  logic [IDX_W-1:0]           wperm_q [1:3];

  // Fade pipeline, one lane per axis.
  logic [16:0]        sq_q    [3], sq_d    [3];
  logic [16:0]        cube_q  [3], cube_d  [3];
  logic signed [21:0] inner_q [3], inner_d [3];
  logic signed [17:0] fade_d  [3];
  logic signed [17:0] fade_q  [4:14][3];

  // Hash tables: one copy per read pair, written in request order.
  logic [IDX_W-1:0]  l1_rd [2];
  logic [IDX_W-1:0]  l2_rd [2][2];
  logic [IDX_W-1:0]  l3_rd [4][2];
  logic [3*GRAD_W-1:0] gr_rd [4][2];

  pn3d_ram #(.DATA_W(IDX_W), .DEPTH(TABLE_SIZE)) u_perm_l1 (
    .clk_i   (clk_i),
    .we_i    (en && vld_q[1] && func_q[1] == FUNC_PERM),
    .waddr_i (widx_q[1]),
    .wdata_i (wperm_q[1]),
    .re_i    (en),
    .raddr0_i(cell_q[1][0]),
    .raddr1_i(cell_q[1][0] + IDX_W'(1)),
    .rdata0_o(l1_rd[0]),
    .rdata1_o(l1_rd[1])
  );

  for (genvar xb = 0; xb < 2; xb++) begin : g_l2
    pn3d_ram #(.DATA_W(IDX_W), .DEPTH(TABLE_SIZE)) u_perm_l2 (
      .clk_i   (clk_i),
      .we_i    (en && vld_q[2] && func_q[2] == FUNC_PERM),
      .waddr_i (widx_q[2]),
      .wdata_i (wperm_q[2]),
      .re_i    (en),
      .raddr0_i(l1_rd[xb] + cell_q[2][1]),
      .raddr1_i(l1_rd[xb] + cell_q[2][1] + IDX_W'(1)),
      .rdata0_o(l2_rd[xb][0]),
      .rdata1_o(l2_rd[xb][1])
    );
  end

  for (genvar j = 0; j < 4; j++) begin : g_l3
    pn3d_ram #(.DATA_W(IDX_W), .DEPTH(TABLE_SIZE)) u_perm_l3 (
      .clk_i   (clk_i),
      .we_i    (en && vld_q[3] && func_q[3] == FUNC_PERM),
      .waddr_i (widx_q[3]),
      .wdata_i (wperm_q[3]),
      .re_i    (en),
      .raddr0_i(l2_rd[j%2][j/2] + cell_q[3][2]),
      .raddr1_i(l2_rd[j%2][j/2] + cell_q[3][2] + IDX_W'(1)),
      .rdata0_o(l3_rd[j][0]),
      .rdata1_o(l3_rd[j][1])
    );

    pn3d_ram #(.DATA_W(3*GRAD_W), .DEPTH(TABLE_SIZE)) u_grad (
      .clk_i   (clk_i),
      .we_i    (en && vld_q[4] && func_q[4] == FUNC_GRAD),
      .waddr_i (widx_q[4]),
      .wdata_i (wgrad_q[4]),
      .re_i    (en),
      .raddr0_i(l3_rd[j][0]),
      .raddr1_i(l3_rd[j][1]),
      .rdata0_o(gr_rd[j][0]),
      .rdata1_o(gr_rd[j][1])
    );
  end

  // Corner k = {z, y, x} bits; gradient components times corner offsets.
  logic signed [32:0] prod_q [8][3], prod_d [8][3];
  logic signed [19:0] dot_q  [8],    dot_d  [8];

  // Interpolation levels: difference, product, rounded sum.
  logic signed [24:0] dx_q [4], dx_d [4];
  logic signed [23:0] ax8_q [4], ax9_q [4];
  logic signed [42:0] px_q [4], px_d [4];
  logic signed [23:0] lx_q [4], lx_d [4];
  logic signed [24:0] dy_q [2], dy_d [2];
  logic signed [23:0] ay11_q [2], ay12_q [2];
  logic signed [42:0] py_q [2], py_d [2];
  logic signed [23:0] ly_q [2], ly_d [2];
  logic signed [24:0] dz_q, dz_d;
  logic signed [23:0] az14_q, az15_q;
  logic signed [42:0] pz_q, pz_d;
  logic signed [23:0] lz_q, lz_d;

  always_comb begin
    vld_d    = {vld_q[NST-1:1], s_axis_tvalid};
    // Drop writes and unused codes once the last table copy is written.
    vld_d[5] = vld_q[4] && func_q[4] == FUNC_EVAL;
  end

  // Fade: t^2, then t^3 and the inner polynomial, then the final product.
  always_comb begin
    logic [31:0] tt;
    logic [32:0] t3p;
    logic [21:0] f15, s6;
    logic signed [39:0] fp;
    for (int i = 0; i < 3; i++) begin
      tt         = frac_q[1][i] * frac_q[1][i];
      sq_d[i]    = 17'((33'(tt) + 33'd32768) >> 16);
      t3p        = sq_q[i] * frac_q[2][i];
      cube_d[i]  = 17'((34'(t3p) + 34'd32768) >> 16);
      f15        = 22'(frac_q[2][i]) * 22'd15;
      s6         = 22'(sq_q[i]) * 22'd6;
      inner_d[i] = $signed(22'd655360 - f15 + s6);
      fp         = $signed({1'b0, cube_q[i]}) * inner_q[i];
      fade_d[i]  = 18'((fp + 40'sd32768) >>> 16);
    end
  end

  // Dot products: offsets are t or t - 1, i.e. frac with a sign bit of the corner bit.
  always_comb begin
    logic signed [16:0] off;
    logic signed [15:0] gc;
    logic signed [34:0] sum;
    for (int k = 0; k < 8; k++) begin
      for (int c = 0; c < 3; c++) begin
        off          = $signed({k[c], frac_q[5][c]});
        gc           = $signed(gr_rd[k%4][k/4][c*GRAD_W +: GRAD_W]);
        prod_d[k][c] = gc * off;
      end
      sum      = 35'(prod_q[k][0]) + 35'(prod_q[k][1]) + 35'(prod_q[k][2]);
      dot_d[k] = 20'((sum + 35'sd16384) >>> 15);
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      dx_d[j] = 25'(dot_q[2*j+1]) - 25'(dot_q[2*j]);
      px_d[j] = 43'(dx_q[j]) * 43'(fade_q[8][0]);
      lx_d[j] = ax9_q[j] + 24'((px_q[j] + 43'sd32768) >>> 16);
    end
    for (int j = 0; j < 2; j++) begin
      dy_d[j] = 25'(lx_q[2*j+1]) - 25'(lx_q[2*j]);
      py_d[j] = 43'(dy_q[j]) * 43'(fade_q[11][1]);
      ly_d[j] = ay12_q[j] + 24'((py_q[j] + 43'sd32768) >>> 16);
    end
    dz_d = 25'(ly_q[1]) - 25'(ly_q[0]);
    pz_d = 43'(dz_q) * 43'(fade_q[14][2]);
    lz_d = az15_q + 24'((pz_q + 43'sd32768) >>> 16);
  end

  // Add one half and saturate to Q3.16.
  always_comb begin
    logic signed [23:0] g;
    g = lz_q + 24'sd32768;
    if (g > OUT_MAX) begin
      out_d = OUT_MAX[OUT_W-1:0];
    end else if (g < OUT_MIN) begin
      out_d = OUT_MIN[OUT_W-1:0];
    end else begin
      out_d = g[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= vld_d;
      out_vld_q <= vld_q[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Capture the request.
      func_q[1]  <= s_axis_tuser;
      for (int i = 0; i < 3; i++) begin
        cell_q[1][i] <= s_axis_tdata[32*i+FRAC_BITS +: IDX_W];
        frac_q[1][i] <= s_axis_tdata[32*i +: FRAC_BITS];
      end
      widx_q[1]  <= s_axis_tdata[103:96];
      wgrad_q[1] <= s_axis_tdata[151:104];
      wperm_q[1] <= s_axis_tdata[159:152];
      for (int s = 2; s <= 4; s++) begin
        func_q[s]  <= func_q[s-1];
        widx_q[s]  <= widx_q[s-1];
        wgrad_q[s] <= wgrad_q[s-1];
      end
      for (int s = 2; s <= 3; s++) begin
        cell_q[s]  <= cell_q[s-1];
        wperm_q[s] <= wperm_q[s-1];
      end
      for (int s = 2; s <= 5; s++) begin
        frac_q[s] <= frac_q[s-1];
      end
      sq_q    <= sq_d;
      cube_q  <= cube_d;
      inner_q <= inner_d;
      fade_q[4] <= fade_d;
      for (int s = 5; s <= 14; s++) begin
        fade_q[s] <= fade_q[s-1];
      end
      prod_q <= prod_d;
      dot_q  <= dot_d;
      for (int j = 0; j < 4; j++) begin
        ax8_q[j] <= 24'(dot_q[2*j]);
      end
      dx_q   <= dx_d;
      ax9_q  <= ax8_q;
      px_q   <= px_d;
      lx_q   <= lx_d;
      for (int j = 0; j < 2; j++) begin
        ay11_q[j] <= lx_q[2*j];
      end
      dy_q   <= dy_d;
      ay12_q <= ay11_q;
      py_q   <= py_d;
      ly_q   <= ly_d;
      az14_q <= ly_q[0];
      dz_q   <= dz_d;
      az15_q <= az14_q;
      pz_q   <= pz_d;
      lz_q   <= lz_d;
      out_q  <= out_d;
    end
  end

endmodule

FILE: design/pn3d_checker.sv
`include "perlin_noise_3d_top_defines.svh"

module pn3d_checker import pn3d_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_tready_i,
  input logic                 m_tvalid_i,
  input logic                 m_tready_i,
  input logic [M_TDATA_W-1:0] m_tdata_i
);

  `PN3D_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i), "stalled result changed")
  `PN3D_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !m_tvalid_i, s_tready_i, "input blocked with empty output")
  `PN3D_ASSERT_NOW(a_block_on_stall, clk_i, rst_ni, m_tvalid_i && !m_tready_i, !s_tready_i, "input taken while pipe is stalled")

endmodule

bind perlin_noise_3d_top pn3d_checker u_pn3d_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_tready_i(s_axis_tready),
  .m_tvalid_i(m_axis_tvalid),
  .m_tready_i(m_axis_tready),
  .m_tdata_i (m_axis_tdata)
);
